FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TRDP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TRDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/trdp_pkg.sv
// ----------------------------------------------------------------------------
// trdp_pkg
// Shared widths, codes, table request/response types and ring size helper.
// ----------------------------------------------------------------------------
package trdp_pkg;

    localparam int PEND_DEPTH = 32;
    localparam int RING_MAX   = 65536;
    localparam int RING_W     = 17;
    localparam int SLOT_W     = 16;
    localparam int CNT_W      = 32;
    localparam int IDX_W      = 32;
    localparam int TIME_W     = 64;
    localparam int LOST_W     = 37;
    localparam int TAG_W      = 32;
    localparam int KIND_W     = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = CNT_W + IDX_W + TIME_W + 1;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 1 + KIND_W;
    localparam int M_FIELDS_W = TAG_W + IDX_W + 2 * TIME_W + LOST_W + SLOT_W + RING_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_OVERRUN = 2'd1,
        EV_PAIR    = 2'd2,
        EV_DROP    = 2'd3
    } event_t;

    typedef enum logic {
        CMD_COUNT  = 1'b0,
        CMD_RECORD = 1'b1
    } cmd_t;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_RING_RECORDS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_TAG    = 1'd1;

    typedef enum logic [1:0] {
        PT_NONE  = 2'd0,
        PT_CLEAR = 2'd1,
        PT_START = 2'd2,
        PT_END   = 2'd3
    } pt_op_t;

    typedef struct packed {
        logic              fire;
        pt_op_t            op;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] stamp;
    } pt_req_t;

    typedef struct packed {
        logic              hit;
        logic              full;
        logic [TIME_W-1:0] hit_time;
    } pt_resp_t;

    // Clamp the slot count to 1..RING_MAX, then round down to a power of two
    function automatic logic [RING_W-1:0] ring_size_f(input logic [RING_W-1:0] n);
        logic [RING_W-1:0] c;
        logic [RING_W-1:0] p;
        if (n == '0) begin
            c = RING_W'(1);
        end else if (n > RING_W'(RING_MAX)) begin
            c = RING_W'(RING_MAX);
        end else begin
            c = n;
        end
        p = '0;
        for (int i = 0; i < RING_W; i++) begin
            if (c[i]) begin
                p = RING_W'(1) << i;
            end
        end
        return p;
    endfunction

endpackage

FILE: sv/trdp_pend_table.sv
// ----------------------------------------------------------------------------
// trdp_pend_table
// Small CAM of pending start records: parallel index match, lowest-hit and
// lowest-free pick, one update per beat.
// ----------------------------------------------------------------------------
module trdp_pend_table
    import trdp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  pt_req_t  req,
    output pt_resp_t resp
);

    logic [PEND_DEPTH-1:0] valid_reg;
    logic [PEND_DEPTH-1:0] valid_next;
    logic [IDX_W-1:0]      index_reg [PEND_DEPTH];
    logic [TIME_W-1:0]     time_reg  [PEND_DEPTH];

    logic [PEND_DEPTH-1:0] match;
    logic [PEND_DEPTH-1:0] hit_oh;
    logic [PEND_DEPTH-1:0] free_oh;
    logic [PEND_DEPTH-1:0] index_we;
    logic [PEND_DEPTH-1:0] time_we;
    logic [TIME_W-1:0]     hit_time;

    // Compare the key against every live entry
    always_comb begin
        for (int i = 0; i < PEND_DEPTH; i++) begin
            match[i] = valid_reg[i] && (index_reg[i] == req.idx);
        end
    end

    // Lowest matching entry and lowest free entry (free is zero when full)
    assign hit_oh  = match & (~match + PEND_DEPTH'(1));
    assign free_oh = ~valid_reg & (valid_reg + PEND_DEPTH'(1));

    // Select the stored start time of the hit
    always_comb begin
        hit_time = '0;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            hit_time = hit_time | (time_reg[i] & {TIME_W{hit_oh[i]}});
        end
    end

    assign resp.hit      = |match;
    assign resp.full     = &valid_reg;
    assign resp.hit_time = hit_time;

    // Work out the update for this beat
    always_comb begin
        valid_next = valid_reg;
        index_we   = '0;
        time_we    = '0;
        if (req.fire) begin
            unique case (req.op)
                PT_CLEAR: begin
                    valid_next = '0;
                end
                PT_START: begin
                    if (|match) begin
                        time_we = hit_oh;
                    end else begin
                        index_we   = free_oh;
                        time_we    = free_oh;
                        valid_next = valid_reg | free_oh;
                    end
                end
                PT_END: begin
                    valid_next = valid_reg & ~hit_oh;
                end
                default: begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload, written in place
    always_ff @(posedge aclk) begin
        for (int i = 0; i < PEND_DEPTH; i++) begin
            if (index_we[i]) begin
                index_reg[i] <= req.idx;
            end
            if (time_we[i]) begin
                time_reg[i] <= req.stamp;
            end
        end
    end

endmodule

FILE: sv/trace_ring_drain_pairer_top.sv
// ----------------------------------------------------------------------------
// trace_ring_drain_pairer_top
// Drains a trace-record ring: extends producer counts against the read
// cursor, reports overruns, and pairs start/end records into results.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  s_*       | in        | s_tvalid / s_tready | tuser: cmd, kind; tdata: record
//  m_*       | out       | m_tvalid / m_tready | tuser: event; tdata: result
//  cfg_*     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One beat per cycle while the result is not stalled; a beat passes the input register, then the result register.
//  Each beat is worked combinationally from the input register (cursor
//  update plus a 32-entry CAM match) into the result register.
//  Reset clears cursors and the pending table at once; no clearing pass.
//  A stalled result holds the result register; the input register still
//  takes one more beat before s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trace_ring_drain_pairer_top
    import trdp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] producer_count, [63:32] record_index, [127:64] record_time,
    // [128] final_pass, rest zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] cmd, [2:1] record_kind
    input  logic [S_TUSER_W-1:0]  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] tag_out, [63:32] pair_index, [127:64] start_time,
    // [191:128] end_time, [228:192] lost_bytes, [244:229] next_slot,
    // [261:245] records_waiting, [262] forced, rest zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [1:0] event_kind
    output logic [M_TUSER_W-1:0]  m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration and cursor state
    logic [RING_W-1:0]    size_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [CNT_W-1:0]     rc_reg;
    logic [CNT_W-1:0]     rc_next;
    logic [RING_W-1:0]    waiting_reg;
    logic [RING_W-1:0]    waiting_next;

    // Input register
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [S_TUSER_W-1:0] in_user_reg;

    // Result register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    event_t               m_user_reg;

    logic                 consume;
    cmd_t                 cmd;
    logic [CNT_W-1:0]     count;
    logic [KIND_W-1:0]    kind;
    logic [IDX_W-1:0]     idx;
    logic [TIME_W-1:0]    stamp;
    logic                 fin;

    logic [CNT_W-1:0]     avail;
    logic                 overrun;
    logic [RING_W-1:0]    size_m1;

    event_t               ev;
    logic [IDX_W-1:0]     pidx;
    logic [TIME_W-1:0]    st;
    logic [TIME_W-1:0]    et;
    logic [LOST_W-1:0]    lost;
    logic                 forced;
    logic [SLOT_W-1:0]    next_slot;

    pt_req_t              pt_req;
    pt_resp_t             pt_resp;

    // Handshakes
    assign consume   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // Unpack the held beat
    assign cmd   = cmd_t'(in_user_reg[0]);
    assign kind  = in_user_reg[KIND_W:1];
    assign count = in_data_reg[CNT_W-1:0];
    assign idx   = in_data_reg[CNT_W +: IDX_W];
    assign stamp = in_data_reg[CNT_W+IDX_W +: TIME_W];
    assign fin   = in_data_reg[CNT_W+IDX_W+TIME_W];

    // Records between cursor and the extended count
    assign avail   = count - rc_reg;
    assign overrun = avail > CNT_W'(size_reg);
    assign size_m1 = size_reg - RING_W'(1);

    // Cursor update, table request and result fields for one beat
    always_comb begin
        rc_next      = rc_reg;
        waiting_next = waiting_reg;
        ev           = EV_NONE;
        pidx         = '0;
        st           = '0;
        et           = '0;
        lost         = '0;
        forced       = 1'b0;
        pt_req.fire  = consume;
        pt_req.op    = PT_NONE;
        pt_req.idx   = idx;
        pt_req.stamp = stamp;
        if (cmd == CMD_COUNT) begin
            if (overrun) begin
                rc_next      = rc_reg + (avail - CNT_W'(size_reg));
                waiting_next = size_reg;
                ev           = EV_OVERRUN;
                lost         = LOST_W'({avail, 4'b0000});
                pt_req.op    = PT_CLEAR;
            end else begin
                waiting_next = avail[RING_W-1:0];
            end
        end else if (waiting_reg != '0) begin
            rc_next      = rc_reg + CNT_W'(1);
            waiting_next = waiting_reg - RING_W'(1);
            case (kind)
                KIND_START: begin
                    pt_req.op = PT_START;
                    if (!pt_resp.hit && pt_resp.full) begin
                        ev = EV_DROP;
                    end
                end
                KIND_END: begin
                    pt_req.op = PT_END;
                    if (pt_resp.hit) begin
                        ev     = EV_PAIR;
                        pidx   = idx;
                        st     = pt_resp.hit_time;
                        et     = stamp;
                        forced = fin;
                    end
                end
                default: begin
                    pt_req.op = PT_NONE;
                end
            endcase
        end
    end

    assign next_slot = rc_next[SLOT_W-1:0] & size_m1[SLOT_W-1:0];

    trdp_pend_table u_pend_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (pt_req),
        .resp    (pt_resp)
    );

    // Control state: cursors, configuration, beat valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= RING_W'(RING_MAX);
            tag_reg      <= '0;
            rc_reg       <= '0;
            waiting_reg  <= '0;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_RING_RECORDS: size_reg <= ring_size_f(cfg_data[RING_W-1:0]);
                    REG_QUEUE_TAG:    tag_reg  <= cfg_data[TAG_W-1:0];
                    default:          tag_reg  <= tag_reg;
                endcase
            end
            if (consume) begin
                rc_reg      <= rc_next;
                waiting_reg <= waiting_next;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the input beat, load the result beat
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (consume) begin
            m_user_reg <= ev;
            m_data_reg <= M_TDATA_W'({forced, waiting_next, next_slot, lost,
                                      et, st, pidx, tag_reg});
        end
    end

    `TRDP_ASSERT_NEXT(a_record_advances, consume && cmd == CMD_RECORD && waiting_reg != '0, rc_reg == $past(rc_reg) + CNT_W'(1), "record beat did not advance the read cursor")
    `TRDP_ASSERT_NOW(a_lost_only_on_overrun, m_tvalid && m_tuser != EV_OVERRUN, m_tdata[192 +: LOST_W] == '0, "bytes lost reported without an overrun")
    `TRDP_ASSERT_NOW(a_waiting_bounded, 1'b1, waiting_reg <= RING_W'(RING_MAX), "waiting count exceeds the largest ring")
    `TRDP_ASSERT_NEXT(a_overrun_fills_ring, consume && cmd == CMD_COUNT && overrun, waiting_reg == size_reg, "overrun did not leave a full ring waiting")

endmodule
